@@ design/uf_pkg.sv @@
// ----------------------------------------------------------------------------
// uf_pkg
// Shared widths and the command/status bundles between the union-find
// controller and its datapath.
// ----------------------------------------------------------------------------
package uf_pkg;

  // width of an element index on the ports
  localparam int ELEM_W = 10;

  // rank storage
  localparam int RANK_W = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  // commands from controller to datapath
  typedef struct packed {
    logic clr_step;   // write one entry of the clearing pass
    logic load_item;  // latch an accepted request
    logic second;     // keep first root, start walk from second element
    logic follow;     // read parent of the word just read
    logic hop;        // re-point current element to its grandparent
    logic rank_b;     // capture first rank, read second rank
    logic merge;      // link the two roots, update rank
    logic load_out;   // load the result register
  } uf_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_done;     // last entry of the clearing pass
    logic p_is_root;    // element just read points to itself
    logic is_unite;     // held request is a unite
    logic roots_equal;  // both walks ended at the same root
  } uf_sts_t;

endpackage

@@ design/union_find_engine.sv @@
// ----------------------------------------------------------------------------
// union_find_engine
// Disjoint-set engine with path halving and union by rank.
//
// Request channel (in_valid_i / in_stall_o) carries command_i,
// first_element_i and second_element_i; a find (command 0) returns the root
// of the first element, a unite (command 1) links both sets and returns the
// surviving root with merged_o set when two different sets were joined.
// Result channel (out_valid_o / out_stall_i) carries root_o and merged_o,
// one result per request, in order.
// Timing: one request at a time. A find walks the parent chain from the
// first element; a unite walks both chains, then reads both ranks and
// links the roots when they differ. Each hop costs one read of parent then
// grandparent from the parent memory's single read port, with the halving
// write overlapping the next read. With halving, the walks stay short.
// After reset the engine runs a clearing pass over all ELEMENTS entries
// that sets every parent to itself and every rank to zero; in_stall_o is
// high meanwhile. A stalled result stays in the output register; the next
// request is still accepted and waits at its end until the register frees.
// ----------------------------------------------------------------------------
module union_find_engine
  import uf_pkg::*;
#(
  parameter int ELEMENTS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              command_i,
  input  logic [ELEM_W-1:0] first_element_i,
  input  logic [ELEM_W-1:0] second_element_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ELEM_W-1:0] root_o,
  output logic              merged_o
);

  uf_cmd_t cmd;
  uf_sts_t sts;

  // sequencer
  uf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // memories and registers
  uf_dpath #(
    .ELEMENTS(ELEMENTS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .command_i       (command_i),
    .first_element_i (first_element_i),
    .second_element_i(second_element_i),
    .root_o          (root_o),
    .merged_o        (merged_o)
  );

endmodule

@@ design/uf_ram.sv @@
// ----------------------------------------------------------------------------
// uf_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data (old data on a same-address collision).
// ----------------------------------------------------------------------------
module uf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/uf_ctrl.sv @@
// ----------------------------------------------------------------------------
// uf_ctrl
// Sequencer for the union-find engine: clearing pass, parent walks with
// path halving, rank compare and link, and the result handshake.
// ----------------------------------------------------------------------------
module uf_ctrl
  import uf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  uf_sts_t sts_i,
  output uf_cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_READ_P   = 9'b000000100,
    S_CHECK_P  = 9'b000001000,
    S_CHECK_GP = 9'b000010000,
    S_RANK_A   = 9'b000100000,
    S_RANK_B   = 9'b001000000,
    S_MERGE    = 9'b010000000,
    S_DONE     = 9'b100000000
  } uf_state_e;

  uf_state_e state_q, state_d;
  logic      second_q, second_d;
  logic      out_valid_q, out_valid_d;
  logic      out_busy;

  // result register still holds an untaken result
  assign out_busy = out_valid_q & out_stall_i;

  // next state and commands
  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    cmd_o    = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          second_d        = 1'b0;
          state_d         = S_READ_P;
        end
      end
      S_READ_P: begin
        state_d = S_CHECK_P;
      end
      S_CHECK_P: begin
        if (!sts_i.p_is_root) begin
          cmd_o.follow = 1'b1;
          state_d      = S_CHECK_GP;
        end else if (!sts_i.is_unite) begin
          state_d = S_DONE;
        end else if (!second_q) begin
          cmd_o.second = 1'b1;
          second_d     = 1'b1;
          state_d      = S_READ_P;
        end else if (sts_i.roots_equal) begin
          state_d = S_DONE;
        end else begin
          state_d = S_RANK_A;
        end
      end
      S_CHECK_GP: begin
        cmd_o.hop = 1'b1;
        state_d   = S_CHECK_P;
      end
      S_RANK_A: begin
        state_d = S_RANK_B;
      end
      S_RANK_B: begin
        cmd_o.rank_b = 1'b1;
        state_d      = S_MERGE;
      end
      S_MERGE: begin
        cmd_o.merge = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // result valid: set on load, dropped once taken
  assign out_valid_d = cmd_o.load_out | out_busy;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ design/uf_dpath.sv @@
// ----------------------------------------------------------------------------
// uf_dpath
// Datapath of the union-find engine: parent and rank memories, the walk
// pointer, saved first root, clearing counter and the result register.
// ----------------------------------------------------------------------------
module uf_dpath
  import uf_pkg::*;
#(
  parameter int ELEMENTS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  uf_cmd_t           cmd_i,
  output uf_sts_t           sts_o,
  input  logic              command_i,
  input  logic [ELEM_W-1:0] first_element_i,
  input  logic [ELEM_W-1:0] second_element_i,
  output logic [ELEM_W-1:0] root_o,
  output logic              merged_o
);

  localparam int IW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(ELEMENTS - 1);

  // indexes at or above the element count saturate to the last element
  function automatic logic [IW-1:0] clamp(input logic [ELEM_W-1:0] e);
    logic [IW-1:0] r;
    if (32'(e) >= 32'(ELEMENTS)) begin
      r = LAST;
    end else begin
      r = IW'(e);
    end
    return r;
  endfunction

  logic [IW-1:0]     cnt_q;
  logic [IW-1:0]     x_q, b_q, ra_q;
  logic              unite_q, merged_q;
  logic [RANK_W-1:0] rank_a_q;
  logic [ELEM_W-1:0] root_q;
  logic              out_merged_q;

  logic              par_we;
  logic [IW-1:0]     par_waddr, par_wdata, par_raddr, par_rdata;
  logic              rk_we;
  logic [IW-1:0]     rk_waddr, rk_raddr;
  logic [RANK_W-1:0] rk_wdata, rk_rdata;

  logic              a_lower, rank_eq;
  logic [IW-1:0]     winner, loser;

  // union by rank: lower rank goes under the other, ties keep the first root
  assign a_lower = (rank_a_q < rk_rdata);
  assign rank_eq = (rank_a_q == rk_rdata);
  assign winner  = a_lower ? x_q : ra_q;
  assign loser   = a_lower ? ra_q : x_q;

  // parent memory ports
  always_comb begin
    par_we    = 1'b0;
    par_waddr = x_q;
    par_wdata = par_rdata;
    if (cmd_i.clr_step) begin
      par_we    = 1'b1;
      par_waddr = cnt_q;
      par_wdata = cnt_q;
    end else if (cmd_i.hop) begin
      par_we = 1'b1;
    end else if (cmd_i.merge) begin
      par_we    = 1'b1;
      par_waddr = loser;
      par_wdata = winner;
    end
  end

  assign par_raddr = (cmd_i.follow | cmd_i.hop) ? par_rdata : x_q;

  // rank memory ports
  assign rk_we    = cmd_i.clr_step | (cmd_i.merge & rank_eq & (rank_a_q != RANK_MAX));
  assign rk_waddr = cmd_i.clr_step ? cnt_q : ra_q;
  assign rk_wdata = cmd_i.clr_step ? '0 : RANK_W'(rank_a_q + 1'b1);
  assign rk_raddr = cmd_i.rank_b ? x_q : ra_q;

  uf_ram #(
    .WIDTH(IW),
    .DEPTH(ELEMENTS)
  ) u_parent_ram (
    .clk_i  (clk_i),
    .we_i   (par_we),
    .waddr_i(par_waddr),
    .wdata_i(par_wdata),
    .raddr_i(par_raddr),
    .rdata_o(par_rdata)
  );

  uf_ram #(
    .WIDTH(RANK_W),
    .DEPTH(ELEMENTS)
  ) u_rank_ram (
    .clk_i  (clk_i),
    .we_i   (rk_we),
    .waddr_i(rk_waddr),
    .wdata_i(rk_wdata),
    .raddr_i(rk_raddr),
    .rdata_o(rk_rdata)
  );

  // clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.clr_step && (cnt_q != LAST)) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // walk pointer and request registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      x_q      <= clamp(first_element_i);
      b_q      <= clamp(second_element_i);
      unite_q  <= command_i;
      merged_q <= 1'b0;
    end else if (cmd_i.second) begin
      ra_q <= x_q;
      x_q  <= b_q;
    end else if (cmd_i.hop) begin
      x_q <= par_rdata;
    end else if (cmd_i.merge) begin
      x_q      <= winner;
      merged_q <= 1'b1;
    end
    if (cmd_i.rank_b) begin
      rank_a_q <= rk_rdata;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      root_q       <= ELEM_W'(x_q);
      out_merged_q <= merged_q;
    end
  end

  assign sts_o.clr_done    = (cnt_q == LAST);
  assign sts_o.p_is_root   = (par_rdata == x_q);
  assign sts_o.is_unite    = unite_q;
  assign sts_o.roots_equal = (x_q == ra_q);

  assign root_o   = root_q;
  assign merged_o = out_merged_q;

endmodule

@@ tb/tb_union_find_engine.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_union_find_engine
// Self-checking bench for the disjoint-set engine. A software forest with
// path halving and union by rank predicts root and merged for every accepted
// request. Directed requests cover the corner cases, then random requests
// drawn mostly from small element windows grow deep trees. Both channels idle
// at random, and the bench also holds off results for a long stretch and
// pauses requests until the engine drains.
// ----------------------------------------------------------------------------
module tb_union_find_engine;
  import uf_pkg::*;

  localparam int NUM_ELEM     = 1024;
  localparam int RANDOM_ITEMS = 800;
  localparam int IDLE_PCT     = 21;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int WINDOW       = 64;

  localparam logic CMD_FIND  = 1'b0;
  localparam logic CMD_UNITE = 1'b1;

  typedef struct {
    logic [ELEM_W-1:0] root;
    logic              merged;
  } root_result_t;

  // software forest and the queue of roots still owed by the engine
  class set_forest;
    logic [ELEM_W-1:0] parent_of [NUM_ELEM];
    logic [RANK_W-1:0] rank_of [NUM_ELEM];
    root_result_t      owed_q[$];
    int unsigned       failures;

    function new();
      for (int i = 0; i < NUM_ELEM; i++) begin
        parent_of[i] = ELEM_W'(i);
        rank_of[i]   = '0;
      end
      failures = 0;
    endfunction

    function logic [ELEM_W-1:0] clamp(logic [ELEM_W-1:0] e);
      if (int'(e) >= NUM_ELEM) return ELEM_W'(NUM_ELEM - 1);
      return e;
    endfunction

    // walk to the root, pointing each visited node at its grandparent
    function logic [ELEM_W-1:0] find_halving(logic [ELEM_W-1:0] x);
      logic [ELEM_W-1:0] up;
      logic [ELEM_W-1:0] grand;
      while (parent_of[x] != x) begin
        up           = parent_of[x];
        grand        = parent_of[up];
        parent_of[x] = grand;
        x            = grand;
      end
      return x;
    endfunction

    function void note_request(logic cmd, logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b);
      root_result_t      res;
      logic [ELEM_W-1:0] ra;
      logic [ELEM_W-1:0] rb;
      logic [ELEM_W-1:0] tmp;
      res.merged = 1'b0;
      if (cmd == CMD_FIND) begin
        res.root = find_halving(clamp(a));
      end else begin
        ra = find_halving(clamp(a));
        rb = find_halving(clamp(b));
        if (ra == rb) begin
          res.root = ra;
        end else begin
          // lower rank goes under; on a tie the second root goes under
          if (rank_of[ra] < rank_of[rb]) begin
            tmp = ra;
            ra  = rb;
            rb  = tmp;
          end
          parent_of[rb] = ra;
          if (rank_of[ra] == rank_of[rb] && rank_of[ra] < RANK_MAX)
            rank_of[ra] = rank_of[ra] + 1'b1;
          res.root   = ra;
          res.merged = 1'b1;
        end
      end
      owed_q.insert(owed_q.size(), res);
    endfunction

    function void check_result(logic [ELEM_W-1:0] root, logic merged);
      root_result_t want;
      if (owed_q.size() == 0) begin
        $error("result with nothing owed: root %0d merged %0d", root, merged);
        failures++;
        return;
      end
      want = owed_q[0];
      owed_q.delete(0);
      if (root !== want.root) begin
        $error("root mismatch: expected %0d, actual %0d", want.root, root);
        failures++;
      end
      if (merged !== want.merged) begin
        $error("merged mismatch: expected %0d, actual %0d", want.merged, merged);
        failures++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              in_valid_i       = 1'b0;
  logic              in_stall_o;
  logic              command_i        = CMD_FIND;
  logic [ELEM_W-1:0] first_element_i  = '0;
  logic [ELEM_W-1:0] second_element_i = '0;
  logic              out_valid_o;
  logic              out_stall_i      = 1'b0;
  logic [ELEM_W-1:0] root_o;
  logic              merged_o;

  set_forest   forest;
  bit          steady       = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned cycle_count  = 0;

  union_find_engine #(
    .ELEMENTS(NUM_ELEM)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .first_element_i (first_element_i),
    .second_element_i(second_element_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .root_o          (root_o),
    .merged_o        (merged_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // offer one request, with random idle cycles before it
  task automatic send_request(input logic cmd, input logic [ELEM_W-1:0] a,
                              input logic [ELEM_W-1:0] b);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    first_element_i  <= a;
    second_element_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    forest.note_request(cmd, a, b);
  endtask

  // corner cases: extremes, both commands, equal roots, rank ties and swaps
  task automatic run_directed();
    send_request(CMD_FIND,  10'd0,    10'd0);
    send_request(CMD_FIND,  10'd1023, 10'd1023);
    send_request(CMD_UNITE, 10'd0,    10'd1023);
    send_request(CMD_UNITE, 10'd1023, 10'd0);
    send_request(CMD_FIND,  10'd1023, 10'd517);
    send_request(CMD_UNITE, 10'd5,    10'd5);
    send_request(CMD_UNITE, 10'd1,    10'd2);
    send_request(CMD_UNITE, 10'd3,    10'd4);
    send_request(CMD_UNITE, 10'd1,    10'd3);
    send_request(CMD_UNITE, 10'd2,    10'd4);
    send_request(CMD_UNITE, 10'd0,    10'd1);
    send_request(CMD_FIND,  10'd1023, 10'd0);
    send_request(CMD_UNITE, 10'd682,  10'd341);
    send_request(CMD_UNITE, 10'd1022, 10'd682);
    send_request(CMD_UNITE, 10'd4,    10'd341);
    send_request(CMD_FIND,  10'd1022, 10'd1023);
    send_request(CMD_UNITE, 10'd512,  10'd511);
    send_request(CMD_UNITE, 10'd511,  10'd1023);
    send_request(CMD_FIND,  10'd512,  10'd682);
    send_request(CMD_UNITE, 10'd4,    10'd1022);
  endtask

  // mostly a small window so sets merge into deep trees, sometimes anywhere
  function automatic logic [ELEM_W-1:0] pick_element(int base);
    if ($urandom_range(0, 99) < 70) return ELEM_W'(base + $urandom_range(0, WINDOW - 1));
    return ELEM_W'($urandom_range(0, NUM_ELEM - 1));
  endfunction

  task automatic run_random(input int count);
    int   base;
    logic cmd;
    base = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) base = $urandom_range(0, NUM_ELEM / WINDOW - 1) * WINDOW;
      // receiver holds off while requests keep coming
      if (i == 100) hold_request = 1'b1;
      // let the engine drain completely before going on
      if (i == 400) begin
        in_valid_i <= 1'b0;
        while (forest.pending() != 0) @(posedge clk_i);
      end
      steady = (i >= 500 && i < 650);
      cmd = ($urandom_range(0, 1) == 1) ? CMD_UNITE : CMD_FIND;
      send_request(cmd, pick_element(base), pick_element(base));
    end
    steady = 1'b0;
  endtask

  // result side: check accepted results, then pick the next stall
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) forest.check_result(root_o, merged_o);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (steady) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // request side and end of run
  initial begin : stimulus
    forest = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    run_random(RANDOM_ITEMS);
    in_valid_i <= 1'b0;
    while (forest.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (forest.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
